// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent that must be followed next cycle by the consequent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/frc_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed command receiver package
// Frame constants, event codes, phase encoding and shared item types.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

	localparam int MAX_PAYLOAD_BYTES = 16;
	localparam int LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam int ACK_LEN = 2;

	localparam logic [7:0] SOF_BYTE = 8'hAA;
	localparam logic [7:0] ACK_CMD = 8'h81;
	localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_PAYLOAD_BYTES);

	typedef enum logic [2:0] {
		EV_ACK_OK      = 3'd0,
		EV_ACK_BAD_LEN = 3'd1,
		EV_NON_ACK     = 3'd2,
		EV_CHECK_ERR   = 3'd3,
		EV_LEN_TOO_BIG = 3'd4
	} event_t;

	typedef enum logic [4:0] {
		PH_WAIT    = 5'b00001,
		PH_CMD     = 5'b00010,
		PH_LEN     = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	// Byte presented to the deframer for the current cycle.
	typedef struct packed {
		logic       step;
		logic [7:0] rx_byte;
	} step_t;

	// Event produced by the deframer while stepping one byte.
	typedef struct packed {
		logic       valid;
		event_t     event_res;
		logic [7:0] frame_cmd;
		logic [7:0] hdr_len;
		logic [7:0] acked_cmd;
		logic [7:0] ack_status;
	} result_t;

endpackage

`default_nettype wire

// ----- design/frc_if.sv -----
// ----------------------------------------------------------------------------
// Framed command receiver channels
// Valid/ready channels for received bytes and for frame events.
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface frc_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] frame_cmd;
	logic [7:0] hdr_len;
	logic [7:0] acked_cmd;
	logic [7:0] ack_status;

	modport source (
		output valid, output event_res, output frame_cmd, output hdr_len,
		output acked_cmd, output ack_status, input ready
	);
	modport sink (
		input valid, input event_res, input frame_cmd, input hdr_len,
		input acked_cmd, input ack_status, output ready
	);
endinterface

`default_nettype wire

// ----- design/frc_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input byte register
// Holds one accepted byte and releases it to the deframer when the
// result register can take whatever it produces.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_in_stage (
	input  wire logic         clk,
	input  wire logic         arst_n,
	frc_byte_if.sink          rx,
	input  wire logic         take,
	output frc_pkg::step_t    step
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	assign advance  = valid_s1 && take;
	assign rx.ready = !valid_s1 || take;

	assign step.step    = advance;
	assign step.rx_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

`default_nettype wire

// ----- design/frc_deframer.sv -----
// ----------------------------------------------------------------------------
// Frame parser
// Phase machine, running checksum and first two payload bytes; decides
// the event for an oversize length or a check byte.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_deframer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire frc_pkg::step_t  step,
	output frc_pkg::result_t     res
);

	frc_pkg::phase_t            phase_q, phase_n;
	logic [7:0]                 cmd_q, cmd_n;
	logic [frc_pkg::LEN_W-1:0]  len_q, len_n;
	logic [frc_pkg::LEN_W-1:0]  idx_q, idx_n;
	logic [7:0]                 sum_q, sum_n;
	logic [7:0]                 pay0_q, pay1_q;
	logic                       wr0, wr1;
	logic [7:0]                 b;
	logic [7:0]                 sum_add;

	assign b       = step.rx_byte;
	assign sum_add = sum_q + b;

	always_comb begin
		phase_n = phase_q;
		cmd_n   = cmd_q;
		len_n   = len_q;
		idx_n   = idx_q;
		sum_n   = sum_q;
		wr0     = 1'b0;
		wr1     = 1'b0;
		res     = '0;
		res.frame_cmd = cmd_q;

		unique case (phase_q)
			frc_pkg::PH_WAIT: begin
				if (b == frc_pkg::SOF_BYTE) begin
					phase_n = frc_pkg::PH_CMD;
					len_n   = '0;
					idx_n   = '0;
					sum_n   = '0;
				end
			end
			frc_pkg::PH_CMD: begin
				cmd_n   = b;
				sum_n   = b;
				phase_n = frc_pkg::PH_LEN;
			end
			frc_pkg::PH_LEN: begin
				if (b > frc_pkg::MAX_LEN_BYTE) begin
					res.valid     = 1'b1;
					res.event_res = frc_pkg::EV_LEN_TOO_BIG;
					res.hdr_len   = b;
					phase_n = (b == frc_pkg::SOF_BYTE) ? frc_pkg::PH_CMD : frc_pkg::PH_WAIT;
					cmd_n   = '0;
					len_n   = '0;
					idx_n   = '0;
					sum_n   = '0;
				end else begin
					sum_n   = sum_add;
					len_n   = b[frc_pkg::LEN_W-1:0];
					idx_n   = '0;
					phase_n = (b == 8'd0) ? frc_pkg::PH_CHECK : frc_pkg::PH_PAYLOAD;
				end
			end
			frc_pkg::PH_PAYLOAD: begin
				wr0   = (idx_q == frc_pkg::LEN_W'(0));
				wr1   = (idx_q == frc_pkg::LEN_W'(1));
				idx_n = idx_q + frc_pkg::LEN_W'(1);
				sum_n = sum_add;
				if (idx_n >= len_q) begin
					phase_n = frc_pkg::PH_CHECK;
				end
			end
			frc_pkg::PH_CHECK: begin
				res.valid   = 1'b1;
				res.hdr_len = 8'(len_q);
				priority if (b != sum_q) begin
					res.event_res = frc_pkg::EV_CHECK_ERR;
				end else if (cmd_q != frc_pkg::ACK_CMD) begin
					res.event_res = frc_pkg::EV_NON_ACK;
				end else if (len_q != frc_pkg::LEN_W'(frc_pkg::ACK_LEN)) begin
					res.event_res = frc_pkg::EV_ACK_BAD_LEN;
				end else begin
					res.event_res  = frc_pkg::EV_ACK_OK;
					res.acked_cmd  = pay0_q;
					res.ack_status = pay1_q;
				end
				phase_n = (b == frc_pkg::SOF_BYTE) ? frc_pkg::PH_CMD : frc_pkg::PH_WAIT;
				cmd_n   = '0;
				len_n   = '0;
				idx_n   = '0;
				sum_n   = '0;
			end
			default: begin
				phase_n = frc_pkg::PH_WAIT;
				cmd_n   = '0;
				len_n   = '0;
				idx_n   = '0;
				sum_n   = '0;
			end
		endcase

		if (!step.step) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= frc_pkg::PH_WAIT;
			cmd_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
		end else if (step.step) begin
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			len_q   <= len_n;
			idx_q   <= idx_n;
			sum_q   <= sum_n;
		end
	end

	// Payload bytes only matter once written; no reset needed.
	always_ff @(posedge clk) begin
		if (step.step && wr0) begin
			pay0_q <= b;
		end
		if (step.step && wr1) begin
			pay1_q <= b;
		end
	end

endmodule

`default_nettype wire

// ----- design/frc_out_stage.sv -----
// ----------------------------------------------------------------------------
// Event output register
// Registers one event item and holds it until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire frc_pkg::result_t  res,
	input  wire logic              load,
	output logic                   can_load,
	frc_event_if.source            evt
);

	logic             valid_q;
	frc_pkg::result_t res_q;

	assign can_load = !valid_q || evt.ready;

	assign evt.valid      = valid_q;
	assign evt.event_res  = res_q.event_res;
	assign evt.frame_cmd  = res_q.frame_cmd;
	assign evt.hdr_len    = res_q.hdr_len;
	assign evt.acked_cmd  = res_q.acked_cmd;
	assign evt.ack_status = res_q.ack_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (evt.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ----- design/framed_command_receiver_core.sv -----
// ----------------------------------------------------------------------------
// Framed command receiver core
// Deframes SOF, CMD, LEN, PAYLOAD, CHECK byte streams and reports one
// event item per oversize length or per check byte.
// ----------------------------------------------------------------------------
// Path: the byte that causes an event item passes the input register,
//   then the event register, before the item is valid on evt.
// Throughput: one byte per cycle unless an event is held; the phase machine steps once per cycle.
// Backpressure: a held event stalls stepping; the input register still
//   takes one byte while the event waits.
// Reset: arst_n clears phase (waiting for SOF), command, length, index,
//   checksum and both valid flags at once; no clearing pass.
`default_nettype none

module framed_command_receiver_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	frc_byte_if.sink    rx,
	frc_event_if.source evt
);

	// Byte handed to the parser this cycle (qualified by the out register).
	frc_pkg::step_t   step;
	// Event from the parser for that byte, if any.
	frc_pkg::result_t res;
	// Event register is empty or being drained this cycle.
	logic             can_load;

	// Input register: one byte, released only when the result slot is free.
	frc_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (can_load),
		.step   (step)
	);

	// Phase machine, checksum and ACK payload capture.
	frc_deframer u_deframer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.res    (res)
	);

	// Event register; bytes that raise no event just clear or keep it.
	frc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.load     (step.step),
		.can_load (can_load),
		.evt      (evt)
	);

endmodule

`default_nettype wire

// ----- design/frc_checker.sv -----
// ----------------------------------------------------------------------------
// Framed command receiver checker
// Port-level checks on event items, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module frc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] event_res,
	input wire logic [7:0] frame_cmd,
	input wire logic [7:0] hdr_len,
	input wire logic [7:0] acked_cmd,
	input wire logic [7:0] ack_status
);

	logic stalled;
	logic code_ok;
	logic is_ok;
	logic is_big;
	logic ack_zero;
	logic big_len;
	logic ack_hdr;

	assign stalled  = out_valid && !out_ready;
	assign code_ok  = (event_res <= frc_pkg::EV_LEN_TOO_BIG);
	assign is_ok    = (event_res == frc_pkg::EV_ACK_OK);
	assign is_big   = (event_res == frc_pkg::EV_LEN_TOO_BIG);
	assign ack_zero = (acked_cmd == 8'd0) && (ack_status == 8'd0);
	assign big_len  = (hdr_len > frc_pkg::MAX_LEN_BYTE);
	assign ack_hdr  = (frame_cmd == frc_pkg::ACK_CMD) && (hdr_len == 8'(frc_pkg::ACK_LEN));

	`ASSERT_NEXT(a_hold, clk, arst_n, stalled, out_valid && $stable(event_res), "event dropped")
	`ASSERT_CLKD(a_code, clk, arst_n, out_valid |-> code_ok, "event code out of range")
	`ASSERT_CLKD(a_zero, clk, arst_n, (out_valid && !is_ok) |-> ack_zero, "ack fields on non-ack")
	`ASSERT_CLKD(a_big, clk, arst_n, (out_valid && is_big) |-> big_len, "oversize with legal length")
	`ASSERT_CLKD(a_ack, clk, arst_n, (out_valid && is_ok) |-> ack_hdr, "ack ok on wrong header")

endmodule

bind framed_command_receiver_core frc_checker u_frc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (evt.valid),
	.out_ready  (evt.ready),
	.event_res  (evt.event_res),
	.frame_cmd  (evt.frame_cmd),
	.hdr_len    (evt.hdr_len),
	.acked_cmd  (evt.acked_cmd),
	.ack_status (evt.ack_status)
);

`default_nettype wire
